[rtl/core/mam_pkg.sv]
// ----------------------------------------------------------------------------
// mam_pkg
// shared types and constants of the modular add / multiply datapath
// ----------------------------------------------------------------------------
package mam_pkg;

    localparam int unsigned COEFF_W = 32;
    localparam int unsigned PROD_W  = 2 * COEFF_W;
    localparam int unsigned ADDR_W  = 3;

    typedef enum logic {
        REG_MODULUS = 1'b0,
        REG_OP_MODE = 1'b1
    } t_reg_idx;

    typedef enum logic {
        MODE_ADD = 1'b0,
        MODE_MUL = 1'b1
    } t_mode;

    // data handed from one reduction cell to the next
    typedef struct packed {
        logic               valid;
        logic               last;
        t_mode              mode;
        logic [COEFF_W-1:0] q;
        logic [COEFF_W-1:0] rem;
        logic [PROD_W-1:0]  quot;
        logic [COEFF_W-1:0] alt;
    } t_cell;

endpackage

[rtl/core/modular_add_mul_elementwise.sv]
// ----------------------------------------------------------------------------
// modular_add_mul_elementwise
// element-wise modular add or multiply of coefficient pairs
// ----------------------------------------------------------------------------
// channel   | handshake            | payload
// input     | i_start / o_busy     | i_coeff_a, i_coeff_b, i_is_last
// result    | o_valid (strobe)     | o_coeff_out, o_last_out
// config    | apb psel/penable     | paddr, pwdata, prdata
//
// one item per cycle; o_busy is never raised
// each result passes through two front stages, one
// reduction cell per product bit (64), and the output register
// reset clears all valid flags, modulus 12289, mode add
// results cannot be held off and are shown for one cycle
// ----------------------------------------------------------------------------
module modular_add_mul_elementwise
    import mam_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [COEFF_W-1:0] i_coeff_a,
    input  logic [COEFF_W-1:0] i_coeff_b,
    input  logic               i_is_last,
    output logic               o_valid,
    output logic [COEFF_W-1:0] o_coeff_out,
    output logic               o_last_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned CELLS = PROD_W;
    localparam int unsigned LAT   = CELLS + 3;

    logic [COEFF_W-1:0] r_modulus;
    t_mode              r_mode;
    logic               r_valid;
    logic [COEFF_W-1:0] r_coeff;
    logic               r_last;
    logic               wr_en;
    t_reg_idx           reg_sel;
    t_cell              chain [0:CELLS];

    assign pready  = 1'b1;
    assign o_busy  = 1'b0;
    assign reg_sel = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= 32'd12289;
            r_mode    <= MODE_ADD;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_MODULUS: r_modulus <= pwdata;
                REG_OP_MODE: r_mode    <= t_mode'(pwdata[0]);
                default:     r_mode    <= r_mode;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_MODULUS: prdata = r_modulus;
            REG_OP_MODE: prdata = {31'd0, r_mode};
            default:     prdata = '0;
        endcase
    end

    mam_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (i_start && !o_busy),
        .i_coeff_a (i_coeff_a),
        .i_coeff_b (i_coeff_b),
        .i_is_last (i_is_last),
        .i_modulus (r_modulus),
        .i_mode    (r_mode),
        .o_cell    (chain[0])
    );

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        mam_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (chain[g]),
            .o_cell  (chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= chain[CELLS].valid;
        end
    end

    // zero modulus and add mode take the side value
    always_ff @(posedge i_clk) begin
        r_coeff <= (chain[CELLS].mode == MODE_MUL && chain[CELLS].q != '0)
                   ? chain[CELLS].rem : chain[CELLS].alt;
        r_last  <= chain[CELLS].last;
    end

    assign o_valid     = r_valid;
    assign o_coeff_out = r_coeff;
    assign o_last_out  = r_last;

    a_strobe_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, LAT))
        else $error("result strobe without matching item");

    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chain[CELLS].valid && chain[CELLS].q != '0) |-> chain[CELLS].rem < chain[CELLS].q)
        else $error("remainder not below modulus");

    a_mode_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && reg_sel == REG_OP_MODE) |=> r_mode == t_mode'($past(pwdata[0])))
        else $error("mode register write lost");

endmodule

[rtl/core/mam_front.sv]
// ----------------------------------------------------------------------------
// mam_front
// operand capture, full product and modular sum, feeding the reduction chain
// ----------------------------------------------------------------------------
module mam_front
    import mam_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [COEFF_W-1:0] i_coeff_a,
    input  logic [COEFF_W-1:0] i_coeff_b,
    input  logic               i_is_last,
    input  logic [COEFF_W-1:0] i_modulus,
    input  t_mode              i_mode,
    output t_cell              o_cell
);

    logic               r_a_valid;
    logic [COEFF_W-1:0] r_a;
    logic [COEFF_W-1:0] r_b;
    logic               r_a_last;
    logic [COEFF_W-1:0] r_a_q;
    t_mode              r_a_mode;

    logic               r_b_valid;
    logic [PROD_W-1:0]  r_prod;
    logic [COEFF_W-1:0] r_sum;
    logic               r_b_last;
    logic [COEFF_W-1:0] r_b_q;
    t_mode              r_b_mode;

    logic [COEFF_W:0]   n_sum_raw;
    logic [COEFF_W:0]   n_sum_sub;
    logic [COEFF_W-1:0] n_sum;

    always_comb begin
        n_sum_raw = {1'b0, r_a} + {1'b0, r_b};
        n_sum_sub = n_sum_raw - {1'b0, r_a_q};
        n_sum     = (n_sum_raw >= {1'b0, r_a_q}) ? n_sum_sub[COEFF_W-1:0]
                                                 : n_sum_raw[COEFF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_take;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= i_coeff_a;
        r_b      <= i_coeff_b;
        r_a_last <= i_is_last;
        r_a_q    <= i_modulus;
        r_a_mode <= i_mode;
        r_prod   <= PROD_W'(r_a) * PROD_W'(r_b);
        r_sum    <= n_sum;
        r_b_last <= r_a_last;
        r_b_q    <= r_a_q;
        r_b_mode <= r_a_mode;
    end

    always_comb begin
        o_cell.valid = r_b_valid;
        o_cell.last  = r_b_last;
        o_cell.mode  = r_b_mode;
        o_cell.q     = r_b_q;
        o_cell.rem   = '0;
        o_cell.quot  = r_prod;
        // low product word covers a zero modulus
        o_cell.alt   = (r_b_mode == MODE_MUL) ? r_prod[COEFF_W-1:0] : r_sum;
    end

endmodule

[rtl/core/mam_cell.sv]
// ----------------------------------------------------------------------------
// mam_cell
// one restoring-division step: shift in one product bit, subtract q if it fits
// ----------------------------------------------------------------------------
module mam_cell
    import mam_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cell i_cell,
    output t_cell o_cell
);

    t_cell            r_cell;
    logic             r_valid;
    t_cell            n_cell;
    logic [COEFF_W:0] n_trial;
    logic [COEFF_W:0] n_diff;

    always_comb begin
        n_trial = {i_cell.rem, i_cell.quot[PROD_W-1]};
        n_diff  = n_trial - {1'b0, i_cell.q};
        n_cell  = i_cell;
        n_cell.rem  = (n_trial >= {1'b0, i_cell.q}) ? n_diff[COEFF_W-1:0]
                                                    : n_trial[COEFF_W-1:0];
        n_cell.quot = {i_cell.quot[PROD_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    always_comb begin
        o_cell       = r_cell;
        o_cell.valid = r_valid;
    end

endmodule

[dv/mam_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mam_checker
// watches the input and result channels and the register writes, predicts
// each coefficient from the live modulus and mode, and compares in order
// ----------------------------------------------------------------------------
module mam_checker
    import mam_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [COEFF_W-1:0] i_coeff_a,
    input  logic [COEFF_W-1:0] i_coeff_b,
    input  logic               i_is_last,
    input  logic               i_valid,
    input  logic [COEFF_W-1:0] i_coeff_out,
    input  logic               i_last_out,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [ADDR_W-1:0]  i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_pready,
    output int                 o_fail_cnt,
    output int                 o_pending
);

    typedef struct packed {
        logic [COEFF_W-1:0] coeff;
        logic               last;
    } t_coeff_res;

    t_coeff_res         pending_coeffs[$];
    logic [COEFF_W-1:0] cur_q;
    t_mode              cur_mode;

    function automatic logic [COEFF_W-1:0] reduce_pair(
        logic [COEFF_W-1:0] a, logic [COEFF_W-1:0] b,
        logic [COEFF_W-1:0] q, t_mode mode);
        logic [COEFF_W:0]  sum;
        logic [PROD_W-1:0] prod;
        if (mode == MODE_MUL) begin
            prod = {32'd0, a} * {32'd0, b};
            if (q == '0) return prod[COEFF_W-1:0];
            prod = prod % {32'd0, q};
            return prod[COEFF_W-1:0];
        end
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, q}) sum = sum - {1'b0, q};
        return sum[COEFF_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        o_fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_coeff_res got, want;
        if (!i_rst_n) begin
            cur_q    <= 32'd12289;
            cur_mode <= MODE_ADD;
            pending_coeffs.delete();
        end else begin
            if (i_valid) begin
                got = '{coeff: i_coeff_out, last: i_last_out};
                if (pending_coeffs.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", got.coeff));
                end else begin
                    want = pending_coeffs.pop_front();
                    if (got.coeff !== want.coeff)
                        report_mismatch($sformatf("coeff got %h want %h",
                                                  got.coeff, want.coeff));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last got %b want %b",
                                                  got.last, want.last));
                end
            end
            if (i_start && !i_busy)
                pending_coeffs.push_back('{
                    coeff: reduce_pair(i_coeff_a, i_coeff_b, cur_q, cur_mode),
                    last: i_is_last});
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (t_reg_idx'(i_paddr[2]) == REG_MODULUS) cur_q <= i_pwdata;
                else cur_mode <= t_mode'(i_pwdata[0]);
            end
        end
        o_pending = pending_coeffs.size();
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives coefficient pairs and register writes into the modular add /
// multiply block across several modulus and mode settings; the checker
// beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
    import mam_pkg::*;

    localparam int LATENCY   = 67;
    localparam int WDOG_MAX  = 2000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [COEFF_W-1:0] coeff_a = '0;
    logic [COEFF_W-1:0] coeff_b = '0;
    logic               is_last = 1'b0;
    logic               res_valid;
    logic [COEFF_W-1:0] coeff_out;
    logic               last_out;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_cnt;
    int                 pending;
    int                 idle_cycles = 0;
    logic [COEFF_W-1:0] cur_q = 32'd12289;
    bit                 no_gaps = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    modular_add_mul_elementwise u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_coeff_a(coeff_a), .i_coeff_b(coeff_b), .i_is_last(is_last),
        .o_valid(res_valid), .o_coeff_out(coeff_out), .o_last_out(last_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    mam_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_coeff_a(coeff_a), .i_coeff_b(coeff_b), .i_is_last(is_last),
        .i_valid(res_valid), .i_coeff_out(coeff_out), .i_last_out(last_out),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready), .o_fail_cnt(fail_cnt),
        .o_pending(pending)
    );

    // watchdog: cycles with nothing accepted
    always @(posedge clk) begin
        if ((start && !busy) || res_valid || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("[modular_add_mul_elementwise] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MODULUS) cur_q = val;
    endtask

    // one item; start stays high across back-to-back items
    task automatic send_item(input logic [31:0] a, input logic [31:0] b,
                             input logic last);
        start   <= 1'b1;
        coeff_a <= a;
        coeff_b <= b;
        is_last <= last;
        do @(posedge clk); while (busy);
        if (!no_gaps && $urandom_range(99) < 25) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // mostly operands below the modulus, sometimes raw 32-bit noise
    function automatic logic [31:0] pick_coeff();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return $urandom();
        if (sel == 1) return cur_q - 1;
        if (sel == 2) return 32'd0;
        return (cur_q == 0) ? $urandom() : $urandom() % cur_q;
    endfunction

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++)
            send_item(pick_coeff(), pick_coeff(), $urandom_range(7) == 0);
    endtask

    initial begin
        logic [31:0] q_set[6];
        q_set = '{32'd12289, 32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFB, 32'd7681, 32'h8000_0001};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, add mode, then mul mode
        send_item(32'd12288, 32'd1, 1'b0);
        send_item(32'd12288, 32'd12288, 1'b1);
        send_item(32'd0, 32'd0, 1'b0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        drain();
        write_reg(REG_OP_MODE, {31'd0, MODE_MUL});
        send_item(32'd12288, 32'd12288, 1'b0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        drain();
        // modulus zero and one
        write_reg(REG_MODULUS, 32'd0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
        drain();
        write_reg(REG_OP_MODE, {31'd0, MODE_ADD});
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(32'd5, 32'd7, 1'b1);
        drain();
        write_reg(REG_MODULUS, 32'd1);
        send_item(32'd0, 32'd0, 1'b0);
        send_item(32'd1, 32'd0, 1'b1);
        drain();
        write_reg(REG_OP_MODE, {31'd0, MODE_MUL});
        send_item(32'hFFFF_FFFF, 32'd3, 1'b1);
        drain();

        // random phases across settings
        for (int p = 0; p < 12; p++) begin
            write_reg(REG_MODULUS, q_set[p % 6]);
            write_reg(REG_OP_MODE, {31'd0, t_mode'(p[0])});
            no_gaps = (p == 4 || p == 5);
            random_phase(55);
            drain();
        end

        if (fail_cnt == 0)
            $display("[modular_add_mul_elementwise] OK");
        else
            $display("[modular_add_mul_elementwise] ERROR");
        $finish;
    end

endmodule
